// ===== design/obstacle_avoid_drive_controller_assert.svh =====
// Assertion macros used by the drive controller RTL
`ifndef OBSTACLE_AVOID_DRIVE_CONTROLLER_ASSERT_SVH
`define OBSTACLE_AVOID_DRIVE_CONTROLLER_ASSERT_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define ODC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ODC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/odc_pkg.sv =====
// Types and constants for the obstacle-avoiding drive controller
`default_nettype none

package odc_pkg;

  localparam int unsigned CAPTURE_BITS_DEF = 16;

  // item kinds on the slave tuser
  typedef enum logic [1:0] {
    OP_SUPPLY = 2'd0,
    OP_CMD    = 2'd1,
    OP_ECHO   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_VTHR = 3'd0,
    CFG_FULL = 3'd1,
    CFG_SLOW = 3'd2,
    CFG_FAR  = 3'd3,
    CFG_NEAR = 3'd4
  } cfg_e;

  localparam int unsigned CFG_ADDR_BITS = 3;
  localparam int unsigned CFG_DATA_BITS = 12;

  // command bytes (ASCII)
  localparam logic [7:0] CMD_MANUAL = 8'h4D;
  localparam logic [7:0] CMD_AUTO   = 8'h41;
  localparam logic [7:0] CMD_FWD    = 8'h46;
  localparam logic [7:0] CMD_BACK   = 8'h42;
  localparam logic [7:0] CMD_LEFT   = 8'h4C;
  localparam logic [7:0] CMD_RIGHT  = 8'h52;
  localparam logic [7:0] CMD_STOP   = 8'h53;

  // register reset values
  localparam logic [11:0] VTHR_RST = 12'd2482;
  localparam logic [9:0]  FULL_RST = 10'd999;
  localparam logic [9:0]  SLOW_RST = 10'd200;
  localparam logic [10:0] FAR_RST  = 11'd30;
  localparam logic [10:0] NEAR_RST = 11'd10;

  // buzzer compare levels
  localparam logic [9:0] BUZZ_OFF  = 10'd1000;
  localparam logic [9:0] BUZZ_MED  = 10'd500;
  localparam logic [9:0] BUZZ_FULL = 10'd0;

  localparam int unsigned ECHO_DIV  = 58;
  localparam int unsigned DIST_BITS = 11;

endpackage

`default_nettype wire

// ===== design/odc_range.sv =====
// Echo pulse width to centimetres: reciprocal multiply by 1/58, saturating
`default_nettype none

module odc_range #(
  parameter int unsigned CAPTURE_BITS = odc_pkg::CAPTURE_BITS_DEF
) (
  input  wire logic [CAPTURE_BITS-1:0]          width_i,
  output logic      [odc_pkg::DIST_BITS-1:0]    dist_cm_o
);

  // k = W+6 keeps the reciprocal exact for every W-bit width
  localparam int unsigned SHIFT      = CAPTURE_BITS + 6;
  localparam int unsigned RECIP_BITS = CAPTURE_BITS + 1;
  localparam int unsigned PROD_BITS  = CAPTURE_BITS + RECIP_BITS;
  localparam int unsigned QUOT_BITS  = PROD_BITS - SHIFT;
  localparam longint unsigned RECIP  =
    ((64'd1 << SHIFT) + odc_pkg::ECHO_DIV - 1) / odc_pkg::ECHO_DIV;

  logic [RECIP_BITS-1:0] recip;
  logic [PROD_BITS-1:0]  prod;
  logic [QUOT_BITS-1:0]  quot;

  assign recip = RECIP_BITS'(RECIP);
  assign prod  = PROD_BITS'(width_i) * PROD_BITS'(recip);
  assign quot  = prod[PROD_BITS-1:SHIFT];

  if (QUOT_BITS > odc_pkg::DIST_BITS) begin : g_sat
    assign dist_cm_o = (quot > QUOT_BITS'({odc_pkg::DIST_BITS{1'b1}}))
                     ? {odc_pkg::DIST_BITS{1'b1}}
                     : quot[odc_pkg::DIST_BITS-1:0];
  end else begin : g_nosat
    assign dist_cm_o = odc_pkg::DIST_BITS'(quot);
  end

endmodule

`default_nettype wire

// ===== design/obstacle_avoid_drive_controller.sv =====
// Two-motor drive controller: supply, command and echo events to drive state
//
// Slave stream carries one event per transfer, its kind in s_axis_tuser:
// supply sample, command byte or echo edge time. Every accepted event gives
// exactly one result on the master stream: motor duties, reverse pins,
// buzzer compare, sensor arm flag, command acknowledge and last distance,
// all showing the state after the event.
// The result is registered: it is valid in the cycle after the transfer.
// It takes one event per cycle while the master side takes results; the work is a single pass through the
// decode, the echo width subtract and one reciprocal multiply into the state
// and result registers.
// s_axis_tready is high while the result register is empty or being taken,
// so a stalled master side holds the result and stops intake after it.
// Reset empties the result register and loads all state and the config
// registers with their defaults (automatic mode, disarmed, motors stopped,
// buzzer medium). Config writes land at once and are meant for idle time.
`default_nettype none

`include "obstacle_avoid_drive_controller_assert.svh"

module obstacle_avoid_drive_controller #(
  parameter int unsigned CAPTURE_BITS = odc_pkg::CAPTURE_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // config write port
  input  wire logic                               cfg_we_i,
  input  wire logic [odc_pkg::CFG_ADDR_BITS-1:0]  cfg_addr_i,
  input  wire logic [odc_pkg::CFG_DATA_BITS-1:0]  cfg_wdata_i,
  // event stream
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // adc_sample[11:0], command_byte[19:12], capture_time[35:20], zero pad
  input  wire logic [39:0]                        s_axis_tdata,
  // opcode[1:0]
  input  wire logic [1:0]                         s_axis_tuser,
  // result stream
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // right_duty[9:0], left_duty[19:10], right_reverse[20], left_reverse[21],
  // buzzer_duty[31:22], sensor_armed[32], ack_sent[33], distance_cm[44:34], pad
  output logic [47:0]                             m_axis_tdata
);

  // config registers
  logic [11:0] vthr_q;
  logic [9:0]  full_q, slow_q;
  logic [10:0] far_q, near_q;

  // controller state
  logic                    manual_q, manual_d;
  logic [11:0]             supply_q, supply_d;
  logic                    armed_q, armed_d;
  logic                    rising_q, rising_d;
  logic [CAPTURE_BITS-1:0] rise_q, rise_d;
  logic [CAPTURE_BITS-1:0] width_q, width_d;
  logic [10:0]             dist_q, dist_d;
  logic [9:0]              rpwm_q, rpwm_d, lpwm_q, lpwm_d;
  logic                    rback_q, rback_d, lback_q, lback_d;
  logic [9:0]              buzz_q, buzz_d;
  logic                    ack_q, ack_d;
  logic                    valid_q;

  logic                    s_fire;
  odc_pkg::op_e            op;
  logic [11:0]             adc;
  logic [7:0]              cmd;
  logic [CAPTURE_BITS-1:0] echo_t;
  logic [CAPTURE_BITS-1:0] width_next;
  logic [10:0]             dist_cm;
  logic                    supply_ok;
  logic                    drive_ok;

  assign s_axis_tready = !valid_q || m_axis_tready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  assign op     = odc_pkg::op_e'(s_axis_tuser);
  assign adc    = s_axis_tdata[11:0];
  assign cmd    = s_axis_tdata[19:12];
  assign echo_t = CAPTURE_BITS'(s_axis_tdata[35:20]);

  // equal edge times keep the previous width
  assign width_next = (echo_t != rise_q) ? echo_t - rise_q : width_q;

  odc_range #(
    .CAPTURE_BITS (CAPTURE_BITS)
  ) u_range (
    .width_i   (width_next),
    .dist_cm_o (dist_cm)
  );

  assign supply_ok = supply_q >= vthr_q;
  assign drive_ok  = manual_q && supply_ok;

  always_comb begin
    manual_d = manual_q;
    supply_d = supply_q;
    armed_d  = armed_q;
    rising_d = rising_q;
    rise_d   = rise_q;
    width_d  = width_q;
    dist_d   = dist_q;
    rpwm_d   = rpwm_q;
    lpwm_d   = lpwm_q;
    rback_d  = rback_q;
    lback_d  = lback_q;
    buzz_d   = buzz_q;
    ack_d    = ack_q;
    if (s_fire) begin
      ack_d = 1'b0;
      case (op)
        odc_pkg::OP_SUPPLY: begin
          supply_d = adc;
          if (adc >= vthr_q) begin
            if (!manual_q) begin
              armed_d = 1'b1;
            end
          end else begin
            buzz_d  = odc_pkg::BUZZ_OFF;
            armed_d = 1'b0;
            rpwm_d  = '0;
            lpwm_d  = '0;
            rback_d = 1'b0;
            lback_d = 1'b0;
          end
        end
        odc_pkg::OP_CMD: begin
          ack_d = 1'b1;
          case (cmd)
            odc_pkg::CMD_MANUAL: begin
              if (!manual_q) begin
                manual_d = 1'b1;
                armed_d  = 1'b0;
                rpwm_d   = '0;
                lpwm_d   = '0;
                rback_d  = 1'b0;
                lback_d  = 1'b0;
              end
            end
            odc_pkg::CMD_AUTO: begin
              if (manual_q) begin
                manual_d = 1'b0;
                rpwm_d   = '0;
                lpwm_d   = '0;
                rback_d  = 1'b0;
                lback_d  = 1'b0;
                if (supply_ok) begin
                  armed_d = 1'b1;
                end
              end
            end
            odc_pkg::CMD_FWD: begin
              if (drive_ok) begin
                rpwm_d  = full_q;
                lpwm_d  = full_q;
                rback_d = 1'b0;
                lback_d = 1'b0;
              end
            end
            odc_pkg::CMD_BACK: begin
              if (drive_ok) begin
                rpwm_d  = '0;
                lpwm_d  = '0;
                rback_d = 1'b1;
                lback_d = 1'b1;
              end
            end
            odc_pkg::CMD_LEFT: begin
              if (drive_ok) begin
                rpwm_d  = full_q;
                lpwm_d  = '0;
                rback_d = 1'b0;
                lback_d = 1'b1;
              end
            end
            odc_pkg::CMD_RIGHT: begin
              if (drive_ok) begin
                rpwm_d  = '0;
                lpwm_d  = full_q;
                rback_d = 1'b1;
                lback_d = 1'b0;
              end
            end
            odc_pkg::CMD_STOP: begin
              if (manual_q) begin
                rpwm_d  = '0;
                lpwm_d  = '0;
                rback_d = 1'b0;
                lback_d = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
        odc_pkg::OP_ECHO: begin
          if (!manual_q && armed_q) begin
            if (!rising_q) begin
              rise_d   = echo_t;
              rising_d = 1'b1;
            end else begin
              width_d  = width_next;
              dist_d   = dist_cm;
              rising_d = 1'b0;
              rback_d  = 1'b0;
              lback_d  = 1'b0;
              rpwm_d   = '0;
              lpwm_d   = '0;
              if (supply_ok) begin
                // far test first even if the bands overlap
                if (dist_cm >= far_q) begin
                  buzz_d = odc_pkg::BUZZ_OFF;
                  rpwm_d = full_q;
                  lpwm_d = full_q;
                end else if (dist_cm >= near_q) begin
                  buzz_d = odc_pkg::BUZZ_MED;
                  rpwm_d = slow_q;
                  lpwm_d = slow_q;
                end else begin
                  buzz_d = odc_pkg::BUZZ_FULL;
                end
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vthr_q <= odc_pkg::VTHR_RST;
      full_q <= odc_pkg::FULL_RST;
      slow_q <= odc_pkg::SLOW_RST;
      far_q  <= odc_pkg::FAR_RST;
      near_q <= odc_pkg::NEAR_RST;
    end else if (cfg_we_i) begin
      case (odc_pkg::cfg_e'(cfg_addr_i))
        odc_pkg::CFG_VTHR: vthr_q <= cfg_wdata_i;
        odc_pkg::CFG_FULL: full_q <= cfg_wdata_i[9:0];
        odc_pkg::CFG_SLOW: slow_q <= cfg_wdata_i[9:0];
        odc_pkg::CFG_FAR:  far_q  <= cfg_wdata_i[10:0];
        odc_pkg::CFG_NEAR: near_q <= cfg_wdata_i[10:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      manual_q <= 1'b0;
      supply_q <= '0;
      armed_q  <= 1'b0;
      rising_q <= 1'b0;
      rise_q   <= '0;
      width_q  <= '0;
      dist_q   <= '0;
      rpwm_q   <= '0;
      lpwm_q   <= '0;
      rback_q  <= 1'b0;
      lback_q  <= 1'b0;
      buzz_q   <= odc_pkg::BUZZ_MED;
      ack_q    <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      manual_q <= manual_d;
      supply_q <= supply_d;
      armed_q  <= armed_d;
      rising_q <= rising_d;
      rise_q   <= rise_d;
      width_q  <= width_d;
      dist_q   <= dist_d;
      rpwm_q   <= rpwm_d;
      lpwm_q   <= lpwm_d;
      rback_q  <= rback_d;
      lback_q  <= lback_d;
      buzz_q   <= buzz_d;
      ack_q    <= ack_d;
      if (s_fire) begin
        valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        valid_q <= 1'b0;
      end
    end
  end

  // state registers double as the result register: they only move on a transfer, which needs the
  // result register empty or the previous result taken in the same cycle
  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {3'b000, dist_q, ack_q, armed_q, buzz_q,
                          lback_q, rback_q, lpwm_q, rpwm_q};

  `ODC_ASSERT_IMP(a_manual_disarmed, manual_q, !armed_q, "armed in manual mode")
  `ODC_ASSERT_IMP(a_rev_right, rback_q, rpwm_q == '0, "right reverse with forward duty")
  `ODC_ASSERT_IMP(a_rev_left, lback_q, lpwm_q == '0, "left reverse with forward duty")
  `ODC_ASSERT_IMP(a_stall_blocks, valid_q && !m_axis_tready, !s_axis_tready, "intake while stalled")
  `ODC_ASSERT_NXT(a_ack_cmd, s_fire, ack_q == ($past(s_axis_tuser) == odc_pkg::OP_CMD), "ack mismatch")
  `ODC_ASSERT_NXT(a_low_supply, s_fire && op == odc_pkg::OP_SUPPLY && adc < vthr_q, !armed_q && rpwm_q == '0 && lpwm_q == '0, "low supply not handled")

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for the obstacle-avoiding drive controller event stream
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_ITEMS = 213;
  localparam int unsigned REPORT_MAX  = 10;

  // result fields, lowest bit last so the struct maps straight onto tdata
  typedef struct packed {
    logic [10:0] dist_cm;
    logic        ack;
    logic        armed;
    logic [9:0]  buzz;
    logic        lrev;
    logic        rrev;
    logic [9:0]  lduty;
    logic [9:0]  rduty;
  } drive_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [odc_pkg::CFG_ADDR_BITS-1:0] cfg_addr_i;
  logic [odc_pkg::CFG_DATA_BITS-1:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;

  obstacle_avoid_drive_controller u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor copy of the block's registers and state
  logic [11:0] thr_q;
  logic [9:0]  full_q, slow_q;
  logic [10:0] far_q, near_q;
  logic        manual_q, armed_q, rise_seen_q;
  logic [11:0] supply_q;
  logic [15:0] rise_t_q, width_q;
  logic [10:0] dist_q;
  logic [9:0]  rduty_q, lduty_q, buzz_q;
  logic        rrev_q, lrev_q;

  drive_res_t pending_drive_q[$];
  int unsigned fault_cnt = 0;
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  int unsigned quiet_cycles = 0;

  function automatic void note_fault(string what);
    fault_cnt++;
    if (fault_cnt <= REPORT_MAX) $display("%0t ns: %s", $time, what);
  endfunction

  function automatic void set_motors(logic [9:0] rd, logic rb, logic [9:0] ld, logic lb);
    rduty_q = rd;
    rrev_q  = rb;
    lduty_q = ld;
    lrev_q  = lb;
  endfunction

  // advances the predicted state by one event and returns the result it shows
  function automatic drive_res_t predict_drive(odc_pkg::op_e op, logic [11:0] adc,
                                               logic [7:0] cmd, logic [15:0] t);
    drive_res_t r;
    logic       drive_ok;
    r = '0;
    case (op)
      odc_pkg::OP_SUPPLY: begin
        supply_q = adc;
        if (supply_q >= thr_q) begin
          if (!manual_q) armed_q = 1'b1;
        end else begin
          buzz_q  = odc_pkg::BUZZ_OFF;
          armed_q = 1'b0;
          set_motors('0, 1'b0, '0, 1'b0);
        end
      end
      odc_pkg::OP_CMD: begin
        r.ack = 1'b1;
        drive_ok = manual_q && (supply_q >= thr_q);
        case (cmd)
          odc_pkg::CMD_MANUAL: begin
            if (!manual_q) begin
              manual_q = 1'b1;
              armed_q  = 1'b0;
              set_motors('0, 1'b0, '0, 1'b0);
            end
          end
          odc_pkg::CMD_AUTO: begin
            if (manual_q) begin
              manual_q = 1'b0;
              set_motors('0, 1'b0, '0, 1'b0);
              if (supply_q >= thr_q) armed_q = 1'b1;
            end
          end
          odc_pkg::CMD_FWD:   if (drive_ok) set_motors(full_q, 1'b0, full_q, 1'b0);
          odc_pkg::CMD_BACK:  if (drive_ok) set_motors('0, 1'b1, '0, 1'b1);
          odc_pkg::CMD_LEFT:  if (drive_ok) set_motors(full_q, 1'b0, '0, 1'b1);
          odc_pkg::CMD_RIGHT: if (drive_ok) set_motors('0, 1'b1, full_q, 1'b0);
          odc_pkg::CMD_STOP:  if (manual_q) set_motors('0, 1'b0, '0, 1'b0);
          default: ;
        endcase
      end
      odc_pkg::OP_ECHO: begin
        if (!manual_q && armed_q) begin
          if (!rise_seen_q) begin
            rise_t_q    = t;
            rise_seen_q = 1'b1;
          end else begin
            // equal stamps keep the previous width
            if (t != rise_t_q) width_q = t - rise_t_q;
            dist_q = 11'(width_q / odc_pkg::ECHO_DIV);
            if (supply_q >= thr_q) begin
              if (dist_q >= far_q) begin
                buzz_q = odc_pkg::BUZZ_OFF;
                set_motors(full_q, 1'b0, full_q, 1'b0);
              end else if (dist_q >= near_q) begin
                buzz_q = odc_pkg::BUZZ_MED;
                set_motors(slow_q, 1'b0, slow_q, 1'b0);
              end else begin
                buzz_q = odc_pkg::BUZZ_FULL;
                set_motors('0, 1'b0, '0, 1'b0);
              end
            end else begin
              set_motors('0, 1'b0, '0, 1'b0);
            end
            rise_seen_q = 1'b0;
          end
        end
      end
      default: ;
    endcase
    r.rduty   = rduty_q;
    r.lduty   = lduty_q;
    r.rrev    = rrev_q;
    r.lrev    = lrev_q;
    r.buzz    = buzz_q;
    r.armed   = armed_q;
    r.dist_cm = dist_q;
    return r;
  endfunction

  // fields the event kind does not use are filled with noise
  task automatic send_event(odc_pkg::op_e op, logic [11:0] adc, logic [7:0] cmd,
                            logic [15:0] t);
    if (op != odc_pkg::OP_SUPPLY) adc = 12'($urandom);
    if (op != odc_pkg::OP_CMD) cmd = 8'($urandom);
    if (op != odc_pkg::OP_ECHO) t = 16'($urandom);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata  = {4'b0, t, cmd, adc};
    s_axis_tuser  = op;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_drive_q.push_back(predict_drive(op, adc, cmd, t));
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (pending_drive_q.size() != 0) @(negedge clk_i);
  endtask

  // block must be idle; writes all five registers back to back
  task automatic load_config(logic [11:0] thr, logic [9:0] full, logic [9:0] slow,
                             logic [10:0] far, logic [10:0] near);
    logic [11:0] vals[5];
    vals = '{thr, 12'(full), 12'(slow), 12'(far), 12'(near)};
    for (int i = 0; i < 5; i++) begin
      cfg_we_i    = 1'b1;
      cfg_addr_i  = odc_pkg::cfg_e'(i);
      cfg_wdata_i = vals[i];
      @(negedge clk_i);
    end
    cfg_we_i = 1'b0;
    thr_q  = thr;
    full_q = full;
    slow_q = slow;
    far_q  = far;
    near_q = near;
  endtask

  always @(negedge clk_i) m_axis_tready = ($urandom_range(99) >= stall_pct);

  always @(posedge clk_i) begin : check_result
    drive_res_t seen, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen = drive_res_t'(m_axis_tdata[44:0]);
      if (pending_drive_q.size() == 0) begin
        note_fault($sformatf("result with nothing pending: %h", m_axis_tdata));
      end else begin
        want = pending_drive_q.pop_front();
        if (seen.rduty !== want.rduty)
          note_fault($sformatf("right_duty: expected %0d, got %0d", want.rduty, seen.rduty));
        if (seen.lduty !== want.lduty)
          note_fault($sformatf("left_duty: expected %0d, got %0d", want.lduty, seen.lduty));
        if (seen.rrev !== want.rrev)
          note_fault($sformatf("right_reverse: expected %0d, got %0d", want.rrev, seen.rrev));
        if (seen.lrev !== want.lrev)
          note_fault($sformatf("left_reverse: expected %0d, got %0d", want.lrev, seen.lrev));
        if (seen.buzz !== want.buzz)
          note_fault($sformatf("buzzer_duty: expected %0d, got %0d", want.buzz, seen.buzz));
        if (seen.armed !== want.armed)
          note_fault($sformatf("sensor_armed: expected %0d, got %0d", want.armed, seen.armed));
        if (seen.ack !== want.ack)
          note_fault($sformatf("ack_sent: expected %0d, got %0d", want.ack, seen.ack));
        if (seen.dist_cm !== want.dist_cm)
          note_fault($sformatf("distance_cm: expected %0d, got %0d",
                               want.dist_cm, seen.dist_cm));
      end
    end
  end

  // ends the run if nothing moves on either side for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (rst_ni) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // supply at zero, just under and exactly at the threshold
  task automatic test_supply_levels();
    send_event(odc_pkg::OP_SUPPLY, 12'd0, '0, '0);
    send_event(odc_pkg::OP_SUPPLY, odc_pkg::VTHR_RST - 12'd1, '0, '0);
    send_event(odc_pkg::OP_SUPPLY, odc_pkg::VTHR_RST, '0, '0);
  endtask

  // wrapped width, equal stamps, full-scale width and the slow band
  task automatic test_echo_ranging();
    send_event(odc_pkg::OP_SUPPLY, 12'hFFF, '0, '0);
    send_event(odc_pkg::OP_ECHO, '0, '0, 16'hFFF0);
    send_event(odc_pkg::OP_ECHO, '0, '0, 16'h0010);
    send_event(odc_pkg::OP_ECHO, '0, '0, 16'd100);
    send_event(odc_pkg::OP_ECHO, '0, '0, 16'd100);
    send_event(odc_pkg::OP_ECHO, '0, '0, 16'h0000);
    send_event(odc_pkg::OP_ECHO, '0, '0, 16'hFFFF);
    send_event(odc_pkg::OP_ECHO, '0, '0, 16'd1000);
    send_event(odc_pkg::OP_ECHO, '0, '0, 16'd1000 + 16'(20 * odc_pkg::ECHO_DIV));
  endtask

  // every command, repeated mode changes, a stray byte and the spare opcode
  task automatic test_manual_commands();
    send_event(odc_pkg::OP_CMD, '0, odc_pkg::CMD_MANUAL, '0);
    send_event(odc_pkg::OP_CMD, '0, odc_pkg::CMD_MANUAL, '0);
    send_event(odc_pkg::OP_CMD, '0, odc_pkg::CMD_FWD, '0);
    send_event(odc_pkg::OP_CMD, '0, odc_pkg::CMD_BACK, '0);
    send_event(odc_pkg::OP_CMD, '0, odc_pkg::CMD_LEFT, '0);
    send_event(odc_pkg::OP_CMD, '0, odc_pkg::CMD_RIGHT, '0);
    send_event(odc_pkg::OP_CMD, '0, odc_pkg::CMD_STOP, '0);
    send_event(odc_pkg::OP_CMD, '0, 8'hFF, '0);
    send_event(odc_pkg::OP_CMD, '0, odc_pkg::CMD_AUTO, '0);
    send_event(odc_pkg::OP_CMD, '0, odc_pkg::CMD_AUTO, '0);
    send_event(odc_pkg::OP_NONE, '0, '0, '0);
  endtask

  // threshold raised between edges: falling edge sees a low supply
  task automatic test_threshold_change();
    send_event(odc_pkg::OP_SUPPLY, 12'd3000, '0, '0);
    send_event(odc_pkg::OP_ECHO, '0, '0, 16'd0);
    wait_drained();
    load_config(12'hFFF, full_q, slow_q, far_q, near_q);
    send_event(odc_pkg::OP_ECHO, '0, '0, 16'd600);
    wait_drained();
    load_config(odc_pkg::VTHR_RST, odc_pkg::FULL_RST, odc_pkg::SLOW_RST,
                odc_pkg::FAR_RST, odc_pkg::NEAR_RST);
  endtask

  task automatic next_random_event(output odc_pkg::op_e op, output logic [11:0] adc,
                                   output logic [7:0] cmd, output logic [15:0] t);
    int unsigned k;
    int w;
    k   = $urandom_range(99);
    adc = 12'($urandom);
    cmd = 8'($urandom);
    t   = 16'($urandom);
    if (k < 10) begin
      op = odc_pkg::OP_SUPPLY;
      if ($urandom_range(99) < 75) adc = 12'($urandom_range(4095, thr_q));
      else if (thr_q != 0) adc = 12'($urandom_range(0, thr_q - 1));
    end else if (k < 35) begin
      op = odc_pkg::OP_CMD;
      k  = $urandom_range(99);
      if (k < 6) cmd = odc_pkg::CMD_MANUAL;
      else if (k < 18) cmd = odc_pkg::CMD_AUTO;
      else if (k < 32) cmd = odc_pkg::CMD_FWD;
      else if (k < 44) cmd = odc_pkg::CMD_BACK;
      else if (k < 56) cmd = odc_pkg::CMD_LEFT;
      else if (k < 68) cmd = odc_pkg::CMD_RIGHT;
      else if (k < 80) cmd = odc_pkg::CMD_STOP;
    end else if (k < 96) begin
      op = odc_pkg::OP_ECHO;
      if (rise_seen_q) begin
        // aim the width at the band edges in four of ten draws
        case ($urandom_range(9))
          0:       w = 0;
          1:       w = $urandom_range(65535);
          2, 3:    w = int'(far_q) * odc_pkg::ECHO_DIV + $urandom_range(115)
                       - odc_pkg::ECHO_DIV;
          4, 5:    w = int'(near_q) * odc_pkg::ECHO_DIV + $urandom_range(115)
                       - odc_pkg::ECHO_DIV;
          default: w = $urandom_range(160) * odc_pkg::ECHO_DIV + $urandom_range(57);
        endcase
        t = rise_t_q + 16'(w);
      end
    end else begin
      op = odc_pkg::OP_NONE;
    end
  endtask

  task automatic test_random_traffic();
    odc_pkg::op_e op;
    logic [11:0]  adc;
    logic [7:0]   cmd;
    logic [15:0]  t;
    int unsigned  done;
    bit           paused;
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      case (ph)
        0: load_config(odc_pkg::VTHR_RST, odc_pkg::FULL_RST, odc_pkg::SLOW_RST,
                       odc_pkg::FAR_RST, odc_pkg::NEAR_RST);
        1: load_config(12'd0, 10'd0, 10'd999, 11'd0, 11'd0);
        2: load_config(12'hFFF, 10'd999, 10'd0, 11'd1129, 11'd1129);
        3: load_config(12'd1200, 10'd500, 10'd700, 11'd100, 11'd500);  // near above far
        default: load_config(12'($urandom_range(4095)), 10'($urandom_range(999)),
                             10'($urandom_range(999)), 11'($urandom_range(120)),
                             11'($urandom_range(120)));
      endcase
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 83; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 83; end
        default: begin idle_pct = 21; stall_pct = 21; end
      endcase
      done   = 0;
      paused = 1'b0;
      while (done < PHASE_ITEMS) begin
        next_random_event(op, adc, cmd, t);
        done++;
        send_event(op, adc, cmd, t);
        if (!paused && done >= PHASE_ITEMS / 2) begin
          wait_drained();
          paused = 1'b1;
        end
      end
    end
    idle_pct  = 0;
    stall_pct = 0;
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = odc_pkg::CFG_VTHR;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = odc_pkg::OP_NONE;

    thr_q       = odc_pkg::VTHR_RST;
    full_q      = odc_pkg::FULL_RST;
    slow_q      = odc_pkg::SLOW_RST;
    far_q       = odc_pkg::FAR_RST;
    near_q      = odc_pkg::NEAR_RST;
    manual_q    = 1'b0;
    armed_q     = 1'b0;
    rise_seen_q = 1'b0;
    supply_q    = '0;
    rise_t_q    = '0;
    width_q     = '0;
    dist_q      = '0;
    rduty_q     = '0;
    lduty_q     = '0;
    rrev_q      = 1'b0;
    lrev_q      = 1'b0;
    buzz_q      = odc_pkg::BUZZ_MED;

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_supply_levels();
    test_echo_ranging();
    test_manual_commands();
    test_threshold_change();
    test_random_traffic();

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (pending_drive_q.size() != 0)
      note_fault($sformatf("%0d results never arrived", pending_drive_q.size()));
    if (fault_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== obstacle_avoid_drive_controller.f =====
+incdir+design
design/odc_pkg.sv
design/odc_range.sv
design/obstacle_avoid_drive_controller.sv
bench/tb.sv
